// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the radix-to-ASCII converter modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/ura_pkg.sv -----
// ----------------------------------------------------------------------------
// ura_pkg
// Shared constants and inter-module types of the radix-to-ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ura_pkg;

  // Sizing of the conversion.
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int IN_W        = 64;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int COUNT_OUT_W = 7;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W       = $clog2(MAX_DIGITS);

  // The divider walks the quotient one byte per cycle.
  localparam int CHUNK_W = 8;
  localparam int NCHUNK  = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int QUO_W   = NCHUNK * CHUNK_W;
  localparam int CHK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  // Two digit banks, one per queue slot.
  localparam int BANK_W = 1;
  localparam int ADDR_W = BANK_W + IDX_W;

  // Radix register limits and reset.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);

  // Character mapping.
  localparam logic [RADIX_W-1:0] DEC_BASE   = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(65);

  // Digit write from the divider into the digit RAM.
  typedef struct packed {
    logic               en;
    logic [BANK_W-1:0]  bank;
    logic [IDX_W-1:0]   idx;
    logic [RADIX_W-1:0] digit;
  } dig_wr_t;

  // Finished conversion handed to the queue.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } push_t;

  // Queue status seen by the divider.
  typedef struct packed {
    logic              full;
    logic [BANK_W-1:0] wr_ptr;
  } qstat_t;

  // Queue head seen by the emitter.
  typedef struct packed {
    logic              not_empty;
    logic [CNT_W-1:0]  cnt;
    logic [BANK_W-1:0] rd_ptr;
  } qhead_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ura_front.sv -----
// ----------------------------------------------------------------------------
// ura_front
// Accepts values, holds the radix register and produces the remainders by
// repeated division, one byte of quotient per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ura_front
  import ura_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [IN_W-1:0]    in_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [RADIX_W-1:0] cfg_radix,
  input  wire qstat_t             qstat,
  output push_t                   push,
  output dig_wr_t                 dig_wr
);

  typedef enum logic {F_IDLE, F_DIV} fstate_t;

  fstate_t             state_r, state_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [RADIX_W-1:0]  rem_r, rem_nxt;
  logic [CHK_W-1:0]    idx_r, idx_nxt;
  logic [CHK_W-1:0]    top_r, top_nxt;
  logic                nz_r, nz_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [QUO_W-1:0]    start_quo;
  logic [CHUNK_W-1:0]  chunk;
  logic [CHUNK_W-1:0]  qchunk;
  logic [RADIX_W-1:0]  rem_out;
  logic                nz_cur;
  logic                accept;

  // Highest byte of a value that holds a one bit, zero for zero.
  function automatic logic [CHK_W-1:0] top_chunk(input logic [QUO_W-1:0] v);
    logic [CHK_W-1:0] t;
    t = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (|v[c*CHUNK_W +: CHUNK_W]) t = CHK_W'(c);
    end
    return t;
  endfunction

  // The register write is always taken and saturates into the legal range.
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_radix < RADIX_MIN) begin
      radix_nxt = RADIX_MIN;
    end else if (cfg_radix > RADIX_MAX) begin
      radix_nxt = RADIX_MAX;
    end else begin
      radix_nxt = cfg_radix;
    end
  end

  assign in_stall  = (state_r != F_IDLE) | qstat.full;
  assign accept    = in_valid & ~in_stall;
  assign start_quo = QUO_W'(in_value[VALUE_WIDTH-1:0]);

  // One byte of long division: eight restoring steps on a narrow remainder.
  always_comb begin : div_step
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    chunk = quo_r[idx_r*CHUNK_W +: CHUNK_W];
    r     = rem_r;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      t = {r, chunk[b]};
      if (t >= {1'b0, radix_r}) begin
        qchunk[b] = 1'b1;
        t         = t - {1'b0, radix_r};
      end else begin
        qchunk[b] = 1'b0;
      end
      r = t[RADIX_W-1:0];
    end
    rem_out = r;
  end

  // Sequencing of bytes within a digit and of digits within a value.
  always_comb begin
    state_nxt    = state_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    idx_nxt      = idx_r;
    top_nxt      = top_r;
    nz_nxt       = nz_r;
    n_nxt        = n_r;
    nz_cur       = nz_r | (|qchunk);
    push         = '0;
    dig_wr       = '0;
    dig_wr.bank  = qstat.wr_ptr;
    dig_wr.idx   = n_r[IDX_W-1:0];
    dig_wr.digit = rem_out;
    push.cnt     = n_r + CNT_W'(1);
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          quo_nxt   = start_quo;
          top_nxt   = top_chunk(start_quo);
          idx_nxt   = top_chunk(start_quo);
          rem_nxt   = '0;
          nz_nxt    = 1'b0;
          n_nxt     = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        quo_nxt[idx_r*CHUNK_W +: CHUNK_W] = qchunk;
        // The top byte of the quotient ran empty: skip it from now on.
        if ((idx_r == top_r) && (qchunk == '0) && (top_r != '0)) begin
          top_nxt = top_r - CHK_W'(1);
        end
        if (idx_r == '0) begin
          dig_wr.en = 1'b1;
          n_nxt     = n_r + CNT_W'(1);
          if (!nz_cur || (n_nxt == CNT_W'(MAX_DIGITS))) begin
            push.valid = 1'b1;
            state_nxt  = F_IDLE;
          end else begin
            rem_nxt = '0;
            nz_nxt  = 1'b0;
            idx_nxt = top_nxt;
          end
        end else begin
          idx_nxt = idx_r - CHK_W'(1);
          rem_nxt = rem_out;
          nz_nxt  = nz_cur;
        end
      end
    endcase
  end

  // Control state and the radix register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      radix_r <= RADIX_RESET;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      if (cfg_valid && cfg_ready) radix_r <= radix_nxt;
    end
  end

  // Working quotient and remainder.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    idx_r <= idx_nxt;
    top_r <= top_nxt;
    nz_r  <= nz_nxt;
  end

  `ASSERT_PROP(a_idx_below_top, (state_r == F_DIV) |-> (idx_r <= top_r), "byte index above top")
  `ASSERT_PROP(a_push_with_digit, push.valid |-> dig_wr.en, "push without final digit")

endmodule

`default_nettype wire

// ----- hw/rtl/ura_queue.sv -----
// ----------------------------------------------------------------------------
// ura_queue
// Two-entry queue of finished digit counts. Each slot owns one digit bank.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ura_queue
  import ura_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output qstat_t     qstat,
  output qhead_t     head
);

  logic [CNT_W-1:0]  slot_r [2];
  logic [BANK_W-1:0] wr_ptr_r;
  logic [BANK_W-1:0] rd_ptr_r;
  logic [1:0]        level_r;

  assign qstat.full     = (level_r == 2'd2);
  assign qstat.wr_ptr   = wr_ptr_r;
  assign head.not_empty = (level_r != 2'd0);
  assign head.cnt       = slot_r[rd_ptr_r];
  assign head.rd_ptr    = rd_ptr_r;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + BANK_W'(1);
      if (pop)        rd_ptr_r <= rd_ptr_r + BANK_W'(1);
      unique case ({push.valid, pop})
        2'b10:   level_r <= level_r + 2'd1;
        2'b01:   level_r <= level_r - 2'd1;
        default: level_r <= level_r;
      endcase
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (push.valid) slot_r[wr_ptr_r] <= push.cnt;
  end

  `ASSERT_NEVER(a_no_overflow, push.valid && (level_r == 2'd2) && !pop, "queue overflow")
  `ASSERT_PROP(a_pop_nonempty, pop |-> (level_r != 2'd0), "pop from empty queue")

endmodule

`default_nettype wire

// ----- hw/rtl/ura_back.sv -----
// ----------------------------------------------------------------------------
// ura_back
// Holds the digit RAM and emits the digits of each queued conversion most
// significant first, one character per request.
// ----------------------------------------------------------------------------
`default_nettype none

module ura_back
  import ura_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dig_wr_t                dig_wr,
  input  wire qhead_t                 head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_digit_char,
  output logic                        out_is_last,
  output logic [COUNT_OUT_W-1:0]      out_digit_count
);

  logic [RADIX_W-1:0]     mem_r [2**ADDR_W];
  logic [RADIX_W-1:0]     rdata_r;
  logic                   p_r;
  logic                   p_last_r;
  logic [CNT_W-1:0]       p_cnt_r;
  logic [IDX_W-1:0]       k_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic [COUNT_OUT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0]       rd_pos;
  logic                   last_issue;
  logic                   load_out;
  logic                   issue;

  // Remainder to its ASCII character.
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
    if (d < DEC_BASE) return CHAR_W'(d) + ASCII_ZERO;
    return CHAR_W'(d) - CHAR_W'(DEC_BASE) + ASCII_A;
  endfunction

  // Digits are stored least significant first, so read from the top down.
  assign rd_pos     = head.cnt - CNT_W'(1) - CNT_W'(k_r);
  assign last_issue = ((CNT_W'(k_r) + CNT_W'(1)) == head.cnt);
  assign load_out   = p_r & (~out_valid_r | ~out_stall);
  assign issue      = head.not_empty & (~p_r | load_out);
  assign pop        = issue & last_issue;

  assign out_valid       = out_valid_r;
  assign out_digit_char  = out_char_r;
  assign out_is_last     = out_last_r;
  assign out_digit_count = out_cnt_r;

  // Digit RAM: one write port from the divider, one registered read port.
  always_ff @(posedge clk) begin
    if (dig_wr.en) mem_r[{dig_wr.bank, dig_wr.idx}] <= dig_wr.digit;
    if (issue) begin
      rdata_r  <= mem_r[{head.rd_ptr, rd_pos[IDX_W-1:0]}];
      p_last_r <= last_issue;
      p_cnt_r  <= head.cnt;
    end
  end

  // Read sequencing and output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      p_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        k_r <= last_issue ? '0 : k_r + IDX_W'(1);
      end
      p_r <= issue | (p_r & ~load_out);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= to_ascii(rdata_r);
      out_last_r <= p_last_r;
      out_cnt_r  <= COUNT_OUT_W'(p_cnt_r);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/unsigned_radix_to_ascii_core.sv -----
// Flow: the divider makes each digit one quotient byte per cycle, from the top
//   nonzero byte down to byte zero; the first character then passes the queue,
//   the RAM read register and the output register before it is offered.
// Throughput: one character per cycle while out_stall is low; the next value is
//   taken the cycle after the divider ends unless both digit banks await emission.
// Reset: synchronous, active low; clears control state, radix resets to 16.
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii_core
// Converts 64-bit unsigned values to ASCII digit strings in a base of 2..36.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_radix_to_ascii_core
  import ura_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [IN_W-1:0]        in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_digit_char,
  output logic                        out_is_last,
  output logic [COUNT_OUT_W-1:0]      out_digit_count,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [RADIX_W-1:0]     cfg_radix
);

  qstat_t  qstat;
  qhead_t  head;
  push_t   push;
  dig_wr_t dig_wr;
  logic    pop;

  // Divider side.
  ura_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_radix (cfg_radix),
    .qstat     (qstat),
    .push      (push),
    .dig_wr    (dig_wr)
  );

  // Hand-off between the two sides.
  ura_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  // Character output side.
  ura_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dig_wr          (dig_wr),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_char  (out_digit_char),
    .out_is_last     (out_is_last),
    .out_digit_count (out_digit_count)
  );

endmodule

`default_nettype wire
